/* sv/square_matrix_multiply_macros.svh */
// ----------------------------------------------------------------------------
// Square matrix multiply assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SQUARE_MATRIX_MULTIPLY_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_MACROS_SVH

`ifndef SYNTH

`define SMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("square_matrix_multiply: assertion failed");

`define SMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("square_matrix_multiply: assertion failed");

`else

`define SMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`define SMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/smm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square matrix multiply package
// Field widths, action codes, result limits and controller/datapath structs.
// ----------------------------------------------------------------------------
package smm_pkg;

    localparam int ACTION_W    = 2;
    localparam int FIELD_IDX_W = 4;
    localparam int VALUE_W     = 16;
    localparam int PROD_W      = 35;
    localparam int SIZE_W      = 5;
    localparam int ACC_W       = 36;

    localparam logic [ACTION_W-1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    localparam logic signed [ACC_W-1:0] PROD_MAX = 36'sd17179869183;
    localparam logic signed [ACC_W-1:0] PROD_MIN = -36'sd17179869184;

    typedef struct packed {
        logic              load_a;
        logic              load_b;
        logic              start;
        logic              rd_en;
        logic [SIZE_W-1:0] k;
        logic              emit;
        logic [SIZE_W-1:0] col;
        logic              last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

/* sv/smm_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square matrix multiply channel interfaces
// Valid/ready channels for load/compute items and result elements.
// ----------------------------------------------------------------------------
interface smm_in_if;
    logic                                valid;
    logic                                ready;
    logic [smm_pkg::ACTION_W-1:0]        action;
    logic [smm_pkg::FIELD_IDX_W-1:0]     row;
    logic [smm_pkg::FIELD_IDX_W-1:0]     col;
    logic signed [smm_pkg::VALUE_W-1:0]  value;

    modport source (output valid, action, row, col, value, input ready);
    modport sink   (input valid, action, row, col, value, output ready);
endinterface

interface smm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [smm_pkg::PROD_W-1:0]   product;
    logic [smm_pkg::FIELD_IDX_W-1:0]     out_row;
    logic [smm_pkg::FIELD_IDX_W-1:0]     out_col;
    logic                                last;

    modport source (output valid, product, out_row, out_col, last, input ready);
    modport sink   (input valid, product, out_row, out_col, last, output ready);
endinterface

/* sv/smm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square matrix multiply controller
// Holds the size register and sequences load, MAC, drain and emit phases.
// ----------------------------------------------------------------------------
module smm_ctrl #(
    parameter int MAX_SIZE = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [smm_pkg::SIZE_W-1:0]       i_cfg_wdata,
    input  logic                             i_valid,
    input  logic [smm_pkg::ACTION_W-1:0]     i_action,
    input  logic [smm_pkg::FIELD_IDX_W-1:0]  i_row,
    output logic                             o_ready,
    input  smm_pkg::t_dp_sts                 i_sts,
    output smm_pkg::t_dp_cmd                 o_cmd
);
    import smm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    localparam logic [SIZE_W-1:0] DRAIN_LAST = SIZE_W'(1);

    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] r_cnt, n_cnt;
    logic [SIZE_W-1:0] w_n;
    logic [SIZE_W-1:0] w_n_last;
    logic              w_accept;

    always_comb begin
        w_n = r_size;
        if (r_size == '0) begin
            w_n = SIZE_W'(1);
        end else if (int'(r_size) > MAX_SIZE) begin
            w_n = SIZE_W'(MAX_SIZE);
        end
    end

    assign w_n_last = w_n - SIZE_W'(1);
    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_a = (i_action == ACT_LOAD_A);
                    o_cmd.load_b = (i_action == ACT_LOAD_B);
                    if ((i_action == ACT_COMPUTE) && ({1'b0, i_row} < w_n)) begin
                        o_cmd.start = 1'b1;
                        n_cnt       = '0;
                        n_state     = S_MAC;
                    end
                end
            end
            S_MAC: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.k     = r_cnt;
                if (r_cnt == w_n_last) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + SIZE_W'(1);
                end
            end
            S_DRAIN: begin
                if (r_cnt == DRAIN_LAST) begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_cnt = r_cnt + SIZE_W'(1);
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.col  = r_cnt;
                    o_cmd.last = (r_cnt == w_n_last);
                    if (r_cnt == w_n_last) begin
                        n_cnt   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + SIZE_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_size  <= SIZE_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
        end
    end

endmodule

/* sv/smm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square matrix multiply datapath
// A and B stores, one MAC lane per result column, and the result register.
// ----------------------------------------------------------------------------
module smm_datapath #(
    parameter int MAX_SIZE      = 16,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  smm_pkg::t_dp_cmd                    i_cmd,
    output smm_pkg::t_dp_sts                    o_sts,
    input  logic [smm_pkg::FIELD_IDX_W-1:0]     i_row,
    input  logic [smm_pkg::FIELD_IDX_W-1:0]     i_col,
    input  logic signed [smm_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [smm_pkg::PROD_W-1:0]   o_product,
    output logic [smm_pkg::FIELD_IDX_W-1:0]     o_out_row,
    output logic [smm_pkg::FIELD_IDX_W-1:0]     o_out_col,
    output logic                                o_last
);
    import smm_pkg::*;

    localparam int EL_W  = (ELEMENT_WIDTH < VALUE_W) ? ELEMENT_WIDTH : VALUE_W;
    localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int MUL_W = 2 * EL_W;

    logic signed [EL_W-1:0]         r_a_mem [MAX_SIZE][MAX_SIZE];
    logic [MAX_SIZE-1:0][EL_W-1:0]  r_b_mem [MAX_SIZE];

    logic [IDX_W-1:0]               w_row_idx;
    logic [IDX_W-1:0]               w_col_idx;
    logic [IDX_W-1:0]               w_k_idx;
    logic                           w_in_range;
    logic signed [EL_W-1:0]         w_el;

    logic [IDX_W-1:0]               r_row_idx;
    logic [FIELD_IDX_W-1:0]         r_row;
    logic signed [EL_W-1:0]         r_a_rd;
    logic [MAX_SIZE-1:0][EL_W-1:0]  r_b_rd;
    logic                           r_rd_vld;
    logic                           r_mul_vld;

    logic signed [ACC_W-1:0]        w_acc  [MAX_SIZE];
    logic signed [ACC_W-1:0]        w_next [MAX_SIZE];
    logic signed [ACC_W-1:0]        w_sat;

    logic                           r_o_vld;
    logic signed [PROD_W-1:0]       r_o_product;
    logic [FIELD_IDX_W-1:0]         r_o_row;
    logic [FIELD_IDX_W-1:0]         r_o_col;
    logic                           r_o_last;

    assign w_row_idx  = IDX_W'(i_row);
    assign w_col_idx  = IDX_W'(i_col);
    assign w_k_idx    = IDX_W'(i_cmd.k);
    assign w_in_range = (int'(i_row) < MAX_SIZE) && (int'(i_col) < MAX_SIZE);
    assign w_el       = EL_W'(i_value);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && w_in_range) begin
            r_a_mem[w_row_idx][w_col_idx] <= w_el;
        end
        if (i_cmd.load_b && w_in_range) begin
            r_b_mem[w_row_idx][w_col_idx] <= w_el;
        end
        if (i_cmd.rd_en) begin
            r_a_rd <= r_a_mem[r_row_idx][w_k_idx];
            r_b_rd <= r_b_mem[w_k_idx];
        end
        if (i_cmd.start) begin
            r_row_idx <= w_row_idx;
            r_row     <= i_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.rd_en;
            r_mul_vld <= r_rd_vld;
        end
    end

    for (genvar l = 0; l < MAX_SIZE; l++) begin : g_lane
        logic signed [MUL_W-1:0] r_prod;
        logic signed [ACC_W-1:0] r_acc;

        always_ff @(posedge i_clk) begin
            if (r_rd_vld) begin
                r_prod <= r_a_rd * $signed(r_b_rd[l]);
            end
            if (i_cmd.start) begin
                r_acc <= '0;
            end else if (r_mul_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end else if (i_cmd.emit) begin
                r_acc <= w_next[l];
            end
        end

        assign w_acc[l] = r_acc;

        if (l < MAX_SIZE - 1) begin : g_mid
            assign w_next[l] = w_acc[l+1];
        end else begin : g_end
            assign w_next[l] = '0;
        end
    end

    always_comb begin
        w_sat = w_acc[0];
        if (w_acc[0] > PROD_MAX) begin
            w_sat = PROD_MAX;
        end else if (w_acc[0] < PROD_MIN) begin
            w_sat = PROD_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_vld <= 1'b1;
        end else if (i_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_product <= PROD_W'(w_sat);
            r_o_row     <= r_row;
            r_o_col     <= FIELD_IDX_W'(i_cmd.col);
            r_o_last    <= i_cmd.last;
        end
    end

    assign o_sts.out_free = !r_o_vld || i_ready;
    assign o_valid        = r_o_vld;
    assign o_product      = r_o_product;
    assign o_out_row      = r_o_row;
    assign o_out_col      = r_o_col;
    assign o_last         = r_o_last;

endmodule

/* sv/square_matrix_multiply.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square matrix multiply
// C = A x B for n-by-n signed fixed-point matrices, one result row per item.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries load and compute beats. A load beat writes one element of A
//   or B. A compute beat for row r (r < n) produces the n elements of row r
//   of C on o_out in column order, last set on the final beat. Other beats
//   are taken and dropped.
//   i_cfg_we / i_cfg_wdata set n; write it only while no row is in flight.
// Sequence:
//   One MAC lane per column, fed from a B row read each cycle while in the
//   MAC phase. A row then passes through drain and emit phases; i_in is
//   ready again only once the last element of the row has been emitted.
// Reset:
//   n returns to 16 and no beat is pending; A and B hold garbage until
//   loaded, so load every element a row reads before computing it.
// Stall:
//   A held o_out.ready freezes the emit sequence; no beat is lost.
// ----------------------------------------------------------------------------
`include "square_matrix_multiply_macros.svh"

module square_matrix_multiply #(
    parameter int MAX_SIZE      = 16,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [smm_pkg::SIZE_W-1:0]  i_cfg_wdata,
    smm_in_if.sink                      i_in,
    smm_out_if.source                   o_out
);
    import smm_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_ready;

    smm_ctrl #(
        .MAX_SIZE (MAX_SIZE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_in.valid),
        .i_action    (i_in.action),
        .i_row       (i_in.row),
        .o_ready     (w_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    smm_datapath #(
        .MAX_SIZE      (MAX_SIZE),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_row     (i_in.row),
        .i_col     (i_in.col),
        .i_value   (i_in.value),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_product (o_out.product),
        .o_out_row (o_out.out_row),
        .o_out_col (o_out.out_col),
        .o_last    (o_out.last)
    );

    assign i_in.ready = w_ready;

    `SMM_ASSERT_NEXT(a_row_continues, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.last, o_out.valid)
    `SMM_ASSERT_NOW(a_no_accept_mid_row, i_clk, i_rst_n, o_out.valid && !o_out.last, !i_in.ready)

endmodule

/* verif/square_matrix_multiply_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square matrix multiply testbench
// Loads A and B elements and requests result rows over a range of matrix
// sizes, predicts every result element from a local copy of both matrices
// and checks each output beat in order. Both channels idle in random bursts,
// and one long output stall forces the input to back up.
// ----------------------------------------------------------------------------
module square_matrix_multiply_tb;
    import smm_pkg::*;

    localparam int     ENTRIES  = 256;
    localparam int     SETTLE   = 45;
    localparam int     WATCHDOG = 3000;
    localparam int     HOLD_LEN = 250;
    localparam longint ACC_SAT  = longint'(1) << 40;
    localparam longint SUM_MAX  = 64'sd17179869183;
    localparam longint SUM_MIN  = -64'sd17179869184;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 16'sh8000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 16'sh7fff;

    typedef struct packed {
        logic [ACTION_W-1:0]        action;
        logic [FIELD_IDX_W-1:0]     row;
        logic [FIELD_IDX_W-1:0]     col;
        logic signed [VALUE_W-1:0]  value;
    } t_beat;

    typedef struct packed {
        logic signed [PROD_W-1:0]   product;
        logic [FIELD_IDX_W-1:0]     out_row;
        logic [FIELD_IDX_W-1:0]     out_col;
        logic                       last;
    } t_elem;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_wdata;

    smm_in_if  in_if ();
    smm_out_if out_if ();

    square_matrix_multiply u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // stimulus side
    t_beat       beat_q[$];
    t_beat       nxt_beat;
    logic        a_set[ENTRIES];
    logic        b_set[ENTRIES];
    int          gen_n;
    int          beats_queued;
    logic        quiet;
    int          hold_req;

    // prediction side
    logic signed [VALUE_W-1:0] a_mat[ENTRIES];
    logic signed [VALUE_W-1:0] b_mat[ENTRIES];
    logic [SIZE_W-1:0]         size_reg;
    t_elem                     elem_q[$];
    logic                      in_took;

    int beats_taken;
    int loads_taken;
    int rows_taken;
    int elems_checked;
    int mismatches;
    int leftover;
    int idle_cycles;
    int src_gap;
    int snk_gap;
    int hold_left;
    int hold_seen;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int active_n(input logic [SIZE_W-1:0] s);
        if (s == 0) return 1;
        if (s > 16) return 16;
        return int'(s);
    endfunction

    function automatic void mac_row(input logic [FIELD_IDX_W-1:0] r);
        int     n;
        longint acc;
        t_elem  e;
        n = active_n(size_reg);
        if (int'(r) >= n) return;
        for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < n; k++) begin
                acc += longint'(a_mat[{r, 4'(k)}]) * longint'(b_mat[{4'(k), 4'(j)}]);
                if (acc > ACC_SAT) acc = ACC_SAT;
                else if (acc < -ACC_SAT) acc = -ACC_SAT;
            end
            if (acc > SUM_MAX) acc = SUM_MAX;
            else if (acc < SUM_MIN) acc = SUM_MIN;
            e.product = acc[PROD_W-1:0];
            e.out_row = r;
            e.out_col = 4'(j);
            e.last    = (j == n - 1);
            elem_q.push_back(e);
        end
        rows_taken++;
    endfunction

    function automatic void log_mismatch(input string why, input t_elem want, input t_elem got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: exp product=%0d row=%0d col=%0d last=%0b, got product=%0d row=%0d col=%0d last=%0b",
                     why, want.product, want.out_row, want.out_col, want.last,
                     got.product, got.out_row, got.out_col, got.last);
    endfunction

    // monitor: track the matrices, predict rows, check results, watch for hangs
    always @(posedge i_clk) begin
        t_elem got;
        t_elem want;
        if (!i_rst_n) begin
            in_took     <= 1'b0;
            size_reg    = SIZE_RESET;
            idle_cycles = 0;
        end else begin
            if (i_cfg_we) size_reg = i_cfg_wdata;
            in_took <= in_if.valid && in_if.ready;
            idle_cycles++;
            if (in_if.valid && in_if.ready) begin
                beats_taken++;
                idle_cycles = 0;
                case (in_if.action)
                    ACT_LOAD_A: begin
                        a_mat[{in_if.row, in_if.col}] = in_if.value;
                        loads_taken++;
                    end
                    ACT_LOAD_B: begin
                        b_mat[{in_if.row, in_if.col}] = in_if.value;
                        loads_taken++;
                    end
                    ACT_COMPUTE: mac_row(in_if.row);
                    default: ;
                endcase
            end
            if (out_if.valid && out_if.ready) begin
                idle_cycles = 0;
                got.product = out_if.product;
                got.out_row = out_if.out_row;
                got.out_col = out_if.out_col;
                got.last    = out_if.last;
                if (elem_q.size() == 0) begin
                    log_mismatch("unexpected result", '0, got);
                end else begin
                    want = elem_q.pop_front();
                    elems_checked++;
                    if (got.product !== want.product || got.out_row !== want.out_row ||
                        got.out_col !== want.out_col || got.last !== want.last)
                        log_mismatch("result", want, got);
                end
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // driver: offer pending items, idle in random bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && !in_took) begin
            // hold until the beat is taken
        end else if (src_gap != 0) begin
            src_gap--;
            in_if.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(0, 5);
            in_if.valid <= 1'b0;
        end else if (beat_q.size() != 0) begin
            nxt_beat = beat_q.pop_front();
            in_if.valid  <= 1'b1;
            in_if.action <= nxt_beat.action;
            in_if.row    <= nxt_beat.row;
            in_if.col    <= nxt_beat.col;
            in_if.value  <= nxt_beat.value;
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    // result sink: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
            out_if.ready <= 1'b0;
        end else if (snk_gap != 0) begin
            snk_gap--;
            out_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            snk_gap = $urandom_range(0, 5);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    function automatic void push_beat(input logic [ACTION_W-1:0] act,
                                      input logic [FIELD_IDX_W-1:0] r,
                                      input logic [FIELD_IDX_W-1:0] c,
                                      input logic signed [VALUE_W-1:0] v);
        t_beat b;
        b.action = act;
        b.row    = r;
        b.col    = c;
        b.value  = v;
        if (act == ACT_LOAD_A) a_set[{r, c}] = 1'b1;
        else if (act == ACT_LOAD_B) b_set[{r, c}] = 1'b1;
        beat_q.push_back(b);
        beats_queued++;
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return -16'sd1;
            3: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [FIELD_IDX_W-1:0] rand_idx();
        if ($urandom_range(0, 4) != 0) return 4'($urandom_range(0, gen_n - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    // load whatever the row still lacks, then request it
    function automatic void push_compute(input logic [FIELD_IDX_W-1:0] r);
        for (int k = 0; k < gen_n; k++)
            if (!a_set[{r, 4'(k)}]) push_beat(ACT_LOAD_A, r, 4'(k), rand_value());
        for (int k = 0; k < gen_n; k++)
            for (int j = 0; j < gen_n; j++)
                if (!b_set[{4'(k), 4'(j)}]) push_beat(ACT_LOAD_B, 4'(k), 4'(j), rand_value());
        push_beat(ACT_COMPUTE, r, 4'($urandom), 16'($urandom));
    endfunction

    function automatic void queue_mix(input int count);
        int pick;
        logic [FIELD_IDX_W-1:0] r;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                push_beat(ACT_LOAD_A, rand_idx(), rand_idx(), rand_value());
            end else if (pick < 70) begin
                push_beat(ACT_LOAD_B, rand_idx(), rand_idx(), rand_value());
            end else if (pick < 88) begin
                push_compute(4'($urandom_range(0, gen_n - 1)));
            end else if (pick < 95) begin
                r = 4'($urandom_range(0, 15));
                if (r < gen_n) push_compute(r);
                else push_beat(ACT_COMPUTE, r, 4'($urandom), 16'($urandom));
            end else begin
                push_beat(ACT_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom));
            end
        end
    endfunction

    task automatic set_size(input logic [SIZE_W-1:0] s);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= s;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        gen_n = active_n(s);
    endtask

    task automatic drain();
        while (beats_taken != beats_queued || elem_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        in_if.valid  = 1'b0;
        in_if.action = ACT_LOAD_A;
        in_if.row    = '0;
        in_if.col    = '0;
        in_if.value  = '0;
        out_if.ready = 1'b0;
        quiet        = 1'b0;
        hold_req     = 0;
        hold_seen    = 0;
        hold_left    = 0;
        src_gap      = 0;
        snk_gap      = 0;
        gen_n        = 16;
        beats_queued = 0;
        beats_taken  = 0;
        loads_taken  = 0;
        rows_taken   = 0;
        elems_checked = 0;
        mismatches   = 0;
        leftover     = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            a_set[i] = 1'b0;
            b_set[i] = 1'b0;
            a_mat[i] = '0;
            b_mat[i] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme values, out-of-range rows, unused action
        set_size(5'd2);
        push_beat(ACT_LOAD_A, 4'd0, 4'd0, VAL_MIN);
        push_beat(ACT_LOAD_A, 4'd0, 4'd1, VAL_MAX);
        push_beat(ACT_LOAD_A, 4'd1, 4'd0, -16'sd1);
        push_beat(ACT_LOAD_A, 4'd1, 4'd1, 16'sd0);
        push_beat(ACT_LOAD_B, 4'd0, 4'd0, VAL_MIN);
        push_beat(ACT_LOAD_B, 4'd0, 4'd1, VAL_MIN);
        push_beat(ACT_LOAD_B, 4'd1, 4'd0, VAL_MAX);
        push_beat(ACT_LOAD_B, 4'd1, 4'd1, 16'sd1);
        push_beat(ACT_COMPUTE, 4'd0, 4'd0, 16'sd0);
        push_beat(ACT_COMPUTE, 4'd1, 4'd0, 16'sd0);
        push_beat(ACT_COMPUTE, 4'd2, 4'd0, 16'sd0);
        push_beat(ACT_COMPUTE, 4'd15, 4'd15, VAL_MAX);
        push_beat(ACT_UNUSED, 4'd0, 4'd0, VAL_MAX);
        push_beat(ACT_LOAD_A, 4'd5, 4'd9, VAL_MAX);
        push_beat(ACT_LOAD_B, 4'd15, 4'd15, VAL_MIN);
        push_beat(ACT_LOAD_A, 4'd15, 4'd15, -16'sd1);
        push_beat(ACT_LOAD_B, 4'd1, 4'd1, VAL_MAX);
        push_beat(ACT_COMPUTE, 4'd1, 4'd15, VAL_MIN);
        push_beat(ACT_COMPUTE, 4'd0, 4'd15, VAL_MAX);
        drain();

        set_size(5'd1);
        queue_mix(15);
        drain();

        set_size(5'd0);
        queue_mix(10);
        drain();

        set_size(5'd5);
        queue_mix(25);
        drain();

        set_size(5'd3);
        queue_mix(15);
        drain();

        set_size(5'd8);
        hold_req++;
        queue_mix(25);
        drain();

        // full-size row where every term of column 0 is the most negative square
        set_size(5'd31);
        for (int k = 0; k < 16; k++)
            push_beat(ACT_LOAD_B, 4'(k), 4'd0, VAL_MIN);
        for (int k = 0; k < 16; k++)
            push_beat(ACT_LOAD_A, 4'd0, 4'(k), VAL_MIN);
        push_compute(4'd0);
        push_compute(4'd15);
        drain();

        quiet = 1'b1;
        set_size(5'd16);
        queue_mix(15);
        drain();

        leftover = elem_q.size();
        if (leftover != 0)
            $display("%0d expected result elements never arrived", leftover);
        $display("Run covered %0d beats (%0d loads, %0d result rows) across sizes 0 to 31,",
                 beats_taken, loads_taken, rows_taken);
        $display("with %0d result elements checked and %0d mismatches.",
                 elems_checked, mismatches);
        if (mismatches == 0 && leftover == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/smm_pkg.sv
sv/smm_ifs.sv
sv/smm_ctrl.sv
sv/smm_datapath.sv
sv/square_matrix_multiply.sv
verif/square_matrix_multiply_tb.sv
